[src/ocv_pkg.sv]
`default_nettype none

package ocv_pkg;

    localparam int MAX_DIM_DEF = 4;
    localparam int SAMPLE_W    = 16;
    localparam int FRAC_W      = 16;
    localparam int MEAN_W      = 34;
    localparam int COM_W       = 64;
    localparam int CNT_W       = 32;
    localparam int CFG_W       = 3;
    localparam int MAG_W       = 33;
    localparam int PROD_W      = 51;

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(4);

    typedef enum logic [1:0] {
        KIND_SAMPLE   = 2'd0,
        KIND_RD_MEAN  = 2'd1,
        KIND_RD_COM   = 2'd2,
        KIND_CLEAR    = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_FIRST,
        S_M_RD,
        S_M_DIFF,
        S_M_DIV,
        S_C_RD,
        S_C_MUL,
        S_C_WR,
        S_RESP
    } t_state;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctrl;

endpackage

`default_nettype wire

[src/ocv_ram.sv]
`default_nettype none

module ocv_ram
    import ocv_pkg::*;
#(
    parameter int DEPTH = 4,
    parameter int WIDTH = 34,
    parameter int AW    = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clear,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    // Entries that were never written since the last clear read as zero.
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/ocv_div.sv]
`default_nettype none

module ocv_div
    import ocv_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [MEAN_W-1:0] i_dividend,
    input  wire logic        [CNT_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic signed      [MEAN_W-1:0] o_quotient
);

    // Restoring division on magnitudes, one quotient bit per cycle.
    localparam int CW = $clog2(MEAN_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic              r_neg;
    logic [MEAN_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;
    logic [CNT_W:0]    w_rem_sh;
    logic              w_ge;

    assign w_rem_sh = {r_rem, r_quo[MEAN_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(MEAN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[MEAN_W-1];
            r_quo <= i_dividend[MEAN_W-1] ? MEAN_W'(-i_dividend) : MEAN_W'(i_dividend);
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[MEAN_W-2:0], w_ge};
            r_rem <= w_ge ? CNT_W'(w_rem_sh - {1'b0, r_dvs}) : CNT_W'(w_rem_sh);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

`default_nettype wire

[src/ocv_mulq.sv]
`default_nettype none

module ocv_mulq
    import ocv_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic signed [MEAN_W-1:0] i_a,
    input  wire logic signed [MEAN_W-1:0] i_b,
    output logic signed      [COM_W-1:0]  o_term
);

    // Two-stage product (a * b) >> 16 with the magnitude truncated.
    // The low half of a is multiplied first, then the high half.
    logic [MEAN_W-1:0]               w_ma;
    logic [MEAN_W-1:0]               w_mb;
    logic [MAG_W-FRAC_W-1:0]         r_hi;
    logic [MAG_W-1:0]                r_mb;
    logic [FRAC_W+MAG_W-1:0]         r_plo;
    logic                            r_neg1;
    logic [PROD_W-1:0]               r_mag;
    logic                            r_neg2;
    logic [COM_W-1:0]                w_mag64;

    assign w_ma = i_a[MEAN_W-1] ? MEAN_W'(-i_a) : MEAN_W'(i_a);
    assign w_mb = i_b[MEAN_W-1] ? MEAN_W'(-i_b) : MEAN_W'(i_b);

    always_ff @(posedge i_clk) begin
        r_hi   <= w_ma[MAG_W-1:FRAC_W];
        r_mb   <= w_mb[MAG_W-1:0];
        r_plo  <= w_ma[FRAC_W-1:0] * w_mb[MAG_W-1:0];
        r_neg1 <= i_a[MEAN_W-1] ^ i_b[MEAN_W-1];
        r_mag  <= PROD_W'(r_hi * r_mb) + PROD_W'(r_plo[FRAC_W+MAG_W-1:FRAC_W]);
        r_neg2 <= r_neg1;
    end

    assign w_mag64 = COM_W'(r_mag);
    assign o_term  = r_neg2 ? -$signed(w_mag64) : $signed(w_mag64);

endmodule

`default_nettype wire

[src/online_covariance_accumulator.sv]
// Clears, non-final sample words and out-of-range reads go from accept straight to S_RESP;
// in-range reads pass S_RD_WAIT first. A final sample word runs the update sequencer: S_FIRST
// on the first sample, else bit-serial division per mean, then the co-moment read-modify-write.
// One word is processed at a time; a new word is taken once the result is in the output register.
// Reset and a clear word zero count, position, flag and the valid bits of both memories at once.
`default_nettype none

module online_covariance_accumulator
    import ocv_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [1:0]                 i_kind,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_value,
    input  wire logic [1:0]                 i_row_index,
    input  wire logic [1:0]                 i_col_index,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic signed [COM_W-1:0]         o_read_value,
    output logic [CNT_W-1:0]                o_sample_count,
    output logic                            o_saturated,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_W-1:0]           i_cfg_data
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CDEPTH = MAX_DIM * MAX_DIM;
    localparam int CA_W   = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int DIM_W  = $clog2(MAX_DIM + 1);

    t_state n_state, r_state;

    logic [CFG_W-1:0]         r_dim_cfg;
    logic [DIM_W-1:0]         w_eff_dim;
    logic [DIM_W-1:0]         r_fdim;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [IDX_W-1:0]         r_pos, n_pos;
    logic                     r_sat, n_sat;
    logic [1:0]               r_kind;
    logic [IDX_W-1:0]         r_r, n_r;
    logic [IDX_W-1:0]         r_c, n_c;
    logic signed [MEAN_W-1:0] r_mean_old;
    logic signed [SAMPLE_W-1:0] r_pend [MAX_DIM];
    logic signed [MEAN_W-1:0] r_diff [MAX_DIM];
    logic signed [MEAN_W-1:0] r_d2   [MAX_DIM];
    logic signed [COM_W-1:0]  r_rv, n_rv;
    logic                     r_out_valid;
    logic signed [COM_W-1:0]  r_out_value;
    logic [CNT_W-1:0]         r_out_count;
    logic                     r_out_sat;

    logic                     w_acc;
    logic                     w_last;
    logic                     w_out_free;
    logic                     w_clear;
    logic                     w_m_we, w_m_re;
    logic [IDX_W-1:0]         w_m_waddr, w_m_raddr;
    logic [MEAN_W-1:0]        w_m_wdata, w_m_rdata;
    logic                     w_c_we, w_c_re;
    logic [CA_W-1:0]          w_c_waddr, w_c_raddr;
    logic [COM_W-1:0]         w_c_wdata, w_c_rdata;
    t_div_ctrl                w_div;
    logic                     ocv_done;
    logic signed [MEAN_W-1:0] w_quot;
    logic signed [MEAN_W-1:0] w_px;
    logic signed [MEAN_W-1:0] w_diff;
    logic signed [MEAN_W-1:0] w_new_mean;
    logic signed [COM_W-1:0]  w_term;
    logic [COM_W:0]           w_sum;
    logic                     w_ovf;
    logic [CA_W-1:0]          w_rc_addr;

    always_comb begin
        if (r_dim_cfg == '0) begin
            w_eff_dim = DIM_W'(1);
        end else if (int'(r_dim_cfg) > MAX_DIM) begin
            w_eff_dim = DIM_W'(MAX_DIM);
        end else begin
            w_eff_dim = DIM_W'(r_dim_cfg);
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_last     = (int'(r_pos) + 1 >= int'(w_eff_dim));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_px       = {{(MEAN_W-SAMPLE_W-FRAC_W){r_pend[r_r][SAMPLE_W-1]}},
                         r_pend[r_r], {FRAC_W{1'b0}}};
    assign w_diff     = w_px - $signed(w_m_rdata);
    assign w_new_mean = r_mean_old + w_quot;
    assign w_rc_addr  = CA_W'(int'(r_r) * MAX_DIM + int'(r_c));
    assign w_sum      = {w_c_rdata[COM_W-1], w_c_rdata} + {w_term[COM_W-1], w_term};
    assign w_ovf      = (w_sum[COM_W] != w_sum[COM_W-1]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_kind)
                        KIND_SAMPLE: begin
                            if (!w_last) begin
                                n_state = S_RESP;
                            end else if (r_count == '0) begin
                                n_state = S_FIRST;
                            end else begin
                                n_state = S_M_RD;
                            end
                        end
                        KIND_RD_MEAN: begin
                            n_state = (int'(i_row_index) < MAX_DIM) ? S_RD_WAIT : S_RESP;
                        end
                        KIND_RD_COM: begin
                            n_state = (int'(i_row_index) < MAX_DIM &&
                                       int'(i_col_index) < MAX_DIM) ? S_RD_WAIT : S_RESP;
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_RD_WAIT: n_state = S_RESP;
            S_FIRST: begin
                if (int'(r_r) + 1 >= int'(r_fdim)) begin
                    n_state = S_RESP;
                end
            end
            S_M_RD:   n_state = S_M_DIFF;
            S_M_DIFF: n_state = S_M_DIV;
            S_M_DIV: begin
                if (w_div.done) begin
                    n_state = (int'(r_r) + 1 >= int'(r_fdim)) ? S_C_RD : S_M_RD;
                end
            end
            S_C_RD:  n_state = S_C_MUL;
            S_C_MUL: n_state = S_C_WR;
            S_C_WR: begin
                if (int'(r_r) + 1 >= int'(r_fdim) && int'(r_c) + 1 >= int'(r_fdim)) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_C_RD;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_pos     = r_pos;
        n_sat     = r_sat;
        n_r       = r_r;
        n_c       = r_c;
        n_rv      = r_rv;
        w_clear   = 1'b0;
        w_m_we    = 1'b0;
        w_m_waddr = r_r;
        w_m_wdata = w_new_mean;
        w_m_re    = 1'b0;
        w_m_raddr = r_r;
        w_c_we    = 1'b0;
        w_c_waddr = w_rc_addr;
        w_c_wdata = w_sum[COM_W-1:0];
        w_c_re    = 1'b0;
        w_c_raddr = w_rc_addr;
        w_div     = '{start: 1'b0, done: 1'b0};
        case (r_state)
            S_IDLE: begin
                n_rv = '0;
                n_r  = '0;
                n_c  = '0;
                if (w_acc) begin
                    case (i_kind)
                        KIND_SAMPLE: begin
                            if (w_last) begin
                                n_pos = '0;
                                if (r_count != '1) begin
                                    n_count = r_count + CNT_W'(1);
                                end
                            end else begin
                                n_pos = r_pos + IDX_W'(1);
                            end
                        end
                        KIND_RD_MEAN: begin
                            w_m_re    = 1'b1;
                            w_m_raddr = IDX_W'(i_row_index);
                        end
                        KIND_RD_COM: begin
                            w_c_re    = 1'b1;
                            w_c_raddr = CA_W'(int'(i_row_index) * MAX_DIM
                                              + int'(i_col_index));
                        end
                        default: begin
                            w_clear = 1'b1;
                            n_count = '0;
                            n_pos   = '0;
                            n_sat   = 1'b0;
                        end
                    endcase
                end
            end
            S_RD_WAIT: begin
                if (r_kind == KIND_RD_MEAN) begin
                    n_rv = COM_W'($signed(w_m_rdata));
                end else begin
                    n_rv = $signed(w_c_rdata);
                end
            end
            S_FIRST: begin
                w_m_we    = 1'b1;
                w_m_wdata = w_px;
                n_r       = r_r + IDX_W'(1);
            end
            S_M_RD: begin
                w_m_re = 1'b1;
            end
            S_M_DIFF: begin
                w_div.start = 1'b1;
            end
            S_M_DIV: begin
                w_div.done = ocv_done;
                if (w_div.done) begin
                    w_m_we = 1'b1;
                    if (int'(r_r) + 1 >= int'(r_fdim)) begin
                        n_r = '0;
                    end else begin
                        n_r = r_r + IDX_W'(1);
                    end
                end
            end
            S_C_RD: begin
                w_c_re = 1'b1;
            end
            S_C_WR: begin
                w_c_we = 1'b1;
                if (w_ovf) begin
                    n_sat     = 1'b1;
                    w_c_wdata = w_term[COM_W-1] ? {1'b1, {(COM_W-1){1'b0}}}
                                                : {1'b0, {(COM_W-1){1'b1}}};
                end
                if (int'(r_c) + 1 >= int'(r_fdim)) begin
                    n_c = '0;
                    n_r = r_r + IDX_W'(1);
                end else begin
                    n_c = r_c + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dim_cfg   <= DIM_RESET;
            r_count     <= '0;
            r_pos       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_sat   <= n_sat;
            if (i_cfg_we) begin
                r_dim_cfg <= i_cfg_data;
            end
            if (r_state == S_RESP && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_r  <= n_r;
        r_c  <= n_c;
        r_rv <= n_rv;
        if (w_acc) begin
            r_kind <= i_kind;
            r_fdim <= w_eff_dim;
            if (i_kind == KIND_SAMPLE) begin
                r_pend[r_pos] <= i_sample_value;
            end
        end
        if (r_state == S_M_DIFF) begin
            r_diff[r_r] <= w_diff;
            r_mean_old  <= $signed(w_m_rdata);
        end
        if (w_div.done) begin
            r_d2[r_r] <= w_px - w_new_mean;
        end
        if (r_state == S_RESP && w_out_free) begin
            r_out_value <= r_rv;
            r_out_count <= r_count;
            r_out_sat   <= r_sat;
        end
    end

    ocv_ram #(
        .DEPTH (MAX_DIM),
        .WIDTH (MEAN_W),
        .AW    (IDX_W)
    ) u_mean_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_clear),
        .i_we    (w_m_we),
        .i_waddr (w_m_waddr),
        .i_wdata (w_m_wdata),
        .i_re    (w_m_re),
        .i_raddr (w_m_raddr),
        .o_rdata (w_m_rdata)
    );

    ocv_ram #(
        .DEPTH (CDEPTH),
        .WIDTH (COM_W),
        .AW    (CA_W)
    ) u_com_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_clear),
        .i_we    (w_c_we),
        .i_waddr (w_c_waddr),
        .i_wdata (w_c_wdata),
        .i_re    (w_c_re),
        .i_raddr (w_c_raddr),
        .o_rdata (w_c_rdata)
    );

    ocv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div.start),
        .i_dividend (w_diff),
        .i_divisor  (r_count),
        .o_done     (ocv_done),
        .o_quotient (w_quot)
    );

    ocv_mulq u_mul (
        .i_clk  (i_clk),
        .i_a    (r_diff[r_r]),
        .i_b    (r_d2[r_c]),
        .o_term (w_term)
    );

    assign o_out_valid    = r_out_valid;
    assign o_read_value   = r_out_value;
    assign o_sample_count = r_out_count;
    assign o_saturated    = r_out_sat;

endmodule

`default_nettype wire
